@@ design/scmb_pkg.sv @@
// Shared types, codes and helpers for the serial command memory bridge.
package scmb_pkg;

    localparam int ADDR_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 4;

    // command bytes seen on the serial link
    localparam logic [7:0] CMD_BYTE_PING  = 8'd1;
    localparam logic [7:0] CMD_BYTE_LOAD  = 8'd3;
    localparam logic [7:0] CMD_BYTE_EXEC  = 8'd5;
    localparam logic [7:0] CMD_BYTE_JUMP  = 8'd6;
    localparam logic [7:0] CMD_BYTE_READ  = 8'd8;
    localparam logic [7:0] CMD_BYTE_WRITE = 8'd10;

    // answer bytes
    localparam logic [7:0] ANS_PING  = 8'd2;
    localparam logic [7:0] ANS_LOAD  = 8'd4;
    localparam logic [7:0] ANS_EXEC  = 8'd7;
    localparam logic [7:0] ANS_READ  = 8'd9;
    localparam logic [7:0] ANS_WRITE = 8'd11;

    // write item widths in bytes
    localparam logic [2:0] WIDTH_BYTE = 3'd1;
    localparam logic [2:0] WIDTH_HALF = 3'd2;
    localparam logic [2:0] WIDTH_WORD = 3'd4;

    typedef enum logic {
        OP_SERIAL = 1'b0,
        OP_MEMDATA = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_TX   = 3'd0,
        KIND_WR   = 3'd1,
        KIND_RD   = 3'd2,
        KIND_CALL = 3'd3,
        KIND_JUMP = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } size_t_t;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_HDR8  = 4'd1,
        PH_HDR4  = 4'd2,
        PH_LOAD  = 4'd3,
        PH_READ  = 4'd4,
        PH_WIDTH = 4'd5,
        PH_WDATA = 4'd6,
        PH_HALT  = 4'd7
    } phase_t;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_LOAD  = 3'd1,
        CMD_EXEC  = 3'd2,
        CMD_JUMP  = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WRITE = 3'd5
    } cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] address;
        logic [31:0] data;
        size_t_t     size;
        logic        last;
    } result_t;

    // up to two results produced by one item
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

    function automatic result_t mk_result(kind_t kind, logic [31:0] address,
                                          logic [31:0] data, size_t_t size);
        result_t r;
        r.kind    = kind;
        r.address = address;
        r.data    = data;
        r.size    = size;
        r.last    = 1'b0;
        return r;
    endfunction

    function automatic result_t mk_tx(logic [7:0] b);
        return mk_result(KIND_TX, 32'd0, {24'd0, b}, SIZE_BYTE);
    endfunction

endpackage

@@ design/scmb_core.sv @@
// Command decoder and bridge state: turns one item into up to two results.
module scmb_core #(
    parameter int ADDR_WIDTH = scmb_pkg::ADDR_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_fire,
    input  logic                in_op,
    input  logic [7:0]          in_value,
    output scmb_pkg::res_pair_t res
);
    import scmb_pkg::*;

    phase_t                  phase_reg, phase_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [2:0]              hdr_reg, hdr_next;
    logic [31:0]             rem_reg, rem_next;
    logic [ADDR_WIDTH-1:0]   addr_reg, addr_next;
    logic [2:0]              iw_reg, iw_next;
    logic [31:0]             asm_reg, asm_next;

    logic [31:0]             asm_shift;
    logic [31:0]             rem_dec;
    logic [2:0]              hdr_inc;
    logic [ADDR_WIDTH-1:0]   hdr_addr;
    res_pair_t               out;

    assign asm_shift = {asm_reg[23:0], in_value};
    assign rem_dec   = rem_reg - 32'd1;
    assign hdr_inc   = hdr_reg + 3'd1;
    assign hdr_addr  = asm_shift[ADDR_WIDTH-1:0];

    always_comb begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        hdr_next   = hdr_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        iw_next    = iw_reg;
        asm_next   = asm_reg;
        out        = '0;

        if (in_fire && phase_reg != PH_HALT) begin
            if (op_t'(in_op) == OP_MEMDATA) begin
                if (phase_reg == PH_READ) begin
                    out.r0   = mk_tx(in_value);
                    out.count = 2'd1;
                    rem_next = rem_dec;
                    if (rem_dec != 32'd0) begin
                        out.r1    = mk_result(KIND_RD, 32'(addr_reg), 32'd0, SIZE_BYTE);
                        out.count = 2'd2;
                        addr_next = addr_reg + 1'b1;
                    end else begin
                        phase_next = PH_IDLE;
                        cmd_next   = CMD_NONE;
                        hdr_next   = 3'd0;
                    end
                end
            end else begin
                case (phase_reg)
                    PH_IDLE: begin
                        hdr_next = 3'd0;
                        asm_next = 32'd0;
                        case (in_value)
                            CMD_BYTE_PING: begin
                                out.r0    = mk_tx(ANS_PING);
                                out.count = 2'd1;
                            end
                            CMD_BYTE_LOAD: begin
                                cmd_next = CMD_LOAD; phase_next = PH_HDR8;
                            end
                            CMD_BYTE_EXEC: begin
                                cmd_next = CMD_EXEC; phase_next = PH_HDR4;
                            end
                            CMD_BYTE_JUMP: begin
                                cmd_next = CMD_JUMP; phase_next = PH_HDR4;
                            end
                            CMD_BYTE_READ: begin
                                cmd_next = CMD_READ; phase_next = PH_HDR8;
                            end
                            CMD_BYTE_WRITE: begin
                                cmd_next = CMD_WRITE; phase_next = PH_WIDTH;
                            end
                            default: ;
                        endcase
                    end
                    PH_WIDTH: begin
                        if (in_value == {5'd0, WIDTH_BYTE} || in_value == {5'd0, WIDTH_HALF}
                                || in_value == {5'd0, WIDTH_WORD}) begin
                            iw_next    = in_value[2:0];
                            hdr_next   = 3'd0;
                            phase_next = PH_HDR8;
                        end else begin
                            phase_next = PH_IDLE;
                            cmd_next   = CMD_NONE;
                            hdr_next   = 3'd0;
                        end
                    end
                    PH_HDR4: begin
                        asm_next = asm_shift;
                        if (hdr_reg >= 3'd3) begin
                            addr_next = hdr_addr;
                            out.r0    = mk_tx(ANS_EXEC);
                            out.count = 2'd2;
                            phase_next = (cmd_reg == CMD_JUMP) ? PH_HALT : PH_IDLE;
                            out.r1 = mk_result((cmd_reg == CMD_JUMP) ? KIND_JUMP : KIND_CALL,
                                               32'(hdr_addr), 32'd0, SIZE_BYTE);
                            cmd_next = CMD_NONE;
                            hdr_next = 3'd0;
                        end else begin
                            hdr_next = hdr_inc;
                        end
                    end
                    PH_HDR8: begin
                        asm_next = asm_shift;
                        if (hdr_reg == 3'd3) begin
                            rem_next = asm_shift;
                        end
                        if (hdr_reg < 3'd7) begin
                            hdr_next = hdr_inc;
                        end else begin
                            addr_next  = hdr_addr;
                            hdr_next   = 3'd0;
                            asm_next   = 32'd0;
                            phase_next = PH_IDLE;
                            cmd_next   = CMD_NONE;
                            case (cmd_reg)
                                CMD_LOAD: begin
                                    if (rem_reg == 32'd0) begin
                                        out.r0    = mk_tx(ANS_LOAD);
                                        out.count = 2'd1;
                                    end else begin
                                        phase_next = PH_LOAD;
                                        cmd_next   = cmd_reg;
                                    end
                                end
                                CMD_READ: begin
                                    out.r0    = mk_tx(ANS_READ);
                                    out.count = 2'd1;
                                    if (rem_reg != 32'd0) begin
                                        out.r1 = mk_result(KIND_RD, 32'(hdr_addr), 32'd0,
                                                           SIZE_BYTE);
                                        out.count  = 2'd2;
                                        addr_next  = hdr_addr + 1'b1;
                                        phase_next = PH_READ;
                                        cmd_next   = cmd_reg;
                                    end
                                end
                                CMD_WRITE: begin
                                    if (rem_reg == 32'd0) begin
                                        out.r0    = mk_tx(ANS_WRITE);
                                        out.count = 2'd1;
                                    end else begin
                                        phase_next = PH_WDATA;
                                        cmd_next   = cmd_reg;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                    PH_LOAD: begin
                        out.r0 = mk_result(KIND_WR, 32'(addr_reg), {24'd0, in_value},
                                           SIZE_BYTE);
                        out.count = 2'd1;
                        addr_next = addr_reg + 1'b1;
                        rem_next  = rem_dec;
                        if (rem_dec == 32'd0) begin
                            out.r1     = mk_tx(ANS_LOAD);
                            out.count  = 2'd2;
                            phase_next = PH_IDLE;
                            cmd_next   = CMD_NONE;
                            hdr_next   = 3'd0;
                        end
                    end
                    PH_WDATA: begin
                        asm_next = asm_shift;
                        hdr_next = hdr_inc;
                        if (hdr_inc >= iw_reg) begin
                            if (iw_reg == WIDTH_WORD) begin
                                out.r0 = mk_result(KIND_WR, 32'(addr_reg), asm_shift,
                                                   SIZE_WORD);
                            end else if (iw_reg == WIDTH_HALF) begin
                                out.r0 = mk_result(KIND_WR, 32'(addr_reg),
                                                   {16'd0, asm_shift[15:0]}, SIZE_HALF);
                            end else begin
                                out.r0 = mk_result(KIND_WR, 32'(addr_reg),
                                                   {24'd0, asm_shift[7:0]}, SIZE_BYTE);
                            end
                            out.count = 2'd1;
                            addr_next = addr_reg + ADDR_WIDTH'(iw_reg);
                            hdr_next  = 3'd0;
                            asm_next  = 32'd0;
                            rem_next  = rem_dec;
                            if (rem_dec == 32'd0) begin
                                out.r1     = mk_tx(ANS_WRITE);
                                out.count  = 2'd2;
                                phase_next = PH_IDLE;
                                cmd_next   = CMD_NONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        // flag the final result of this item
        if (out.count == 2'd1) begin
            out.r0.last = 1'b1;
        end
        if (out.count == 2'd2) begin
            out.r1.last = 1'b1;
        end
        res = out;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cmd_reg   <= CMD_NONE;
            hdr_reg   <= 3'd0;
            rem_reg   <= 32'd0;
            addr_reg  <= '0;
            iw_reg    <= 3'd0;
            asm_reg   <= 32'd0;
        end else begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            hdr_reg   <= hdr_next;
            rem_reg   <= rem_next;
            addr_reg  <= addr_next;
            iw_reg    <= iw_next;
            asm_reg   <= asm_next;
        end
    end

    // halt is sticky until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALT |=> phase_reg == PH_HALT)
        else $error("left halt without reset");

    // nothing comes out of a halted bridge
    a_halt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HALT |-> res.count == 2'd0)
        else $error("result produced while halted");

    // in a pair only the second result is marked last
    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        res.count == 2'd2 |-> (res.r1.last && !res.r0.last))
        else $error("bad last marking on result pair");

    // a read stream always has a command behind it
    a_read_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_READ |-> cmd_reg == CMD_READ)
        else $error("read phase without read command");

endmodule

@@ design/scmb_outq.sv @@
// Result queue: takes zero, one or two results a cycle, hands out one.
module scmb_outq (
    input  logic                aclk,
    input  logic                aresetn,
    input  scmb_pkg::res_pair_t push,
    output logic                space_ok,
    output logic                out_valid,
    input  logic                out_ready,
    output scmb_pkg::result_t   out_res
);
    import scmb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t           mem_reg [QUEUE_DEPTH];
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [PW:0]       cnt_reg, cnt_next;
    logic [PW-1:0]     tail_p1;
    logic              pop;

    assign tail_p1   = tail_reg + 1'b1;
    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem_reg[head_reg];
    assign pop       = out_valid && out_ready;
    // room for a full pair
    assign space_ok  = (cnt_reg <= (PW+1)'(QUEUE_DEPTH - 2));

    always_comb begin
        head_next = pop ? head_reg + 1'b1 : head_reg;
        tail_next = tail_reg + PW'(push.count);
        cnt_next  = cnt_reg + (PW+1)'(push.count) - (PW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            mem_reg[tail_reg] <= push.r0;
        end
        if (push.count == 2'd2) begin
            mem_reg[tail_p1] <= push.r1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            cnt_reg  <= cnt_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PW+1)'(QUEUE_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.count != 2'd0 |-> cnt_reg <= (PW+1)'(QUEUE_DEPTH - 2))
        else $error("push without room");

    a_pop_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && push.count == 2'd0) |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("pop did not drain queue");

endmodule

@@ design/serial_command_memory_bridge_top.sv @@
// Top level of the serial command memory bridge.
//
//  channel  | direction | ports                                    | handshake
//  ---------+-----------+------------------------------------------+-------------------
//  input    | in        | s_op, s_value                            | s_valid / s_ready
//  result   | out       | m_kind, m_address, m_data, m_size, m_last| m_valid / m_ready
//
// Each accepted item is decoded in the cycle it arrives; its zero, one or two
// results enter a four-entry result queue at that same edge and show on the
// m_ bus from the next cycle. Sustained rate is one item per cycle while each
// item yields at most one result and m_ready stays high; the queue's single
// read port drains one result per cycle, so a run of pairs holds back s_ready.
// s_ready is high whenever the queue has room for a pair, so the input side
// keeps moving while a result waits on m_ready. Reset (aresetn low at a clock
// edge) returns to idle, clears the halt and empties the queue.
module serial_command_memory_bridge_top #(
    parameter int ADDR_WIDTH = scmb_pkg::ADDR_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_kind,
    output logic [31:0] m_address,
    output logic [31:0] m_data,
    output logic [1:0]  m_size,
    output logic        m_last
);
    import scmb_pkg::*;

    res_pair_t pair;
    result_t   head;
    logic      in_fire;

    assign in_fire = s_valid && s_ready;

    // decode and state update
    scmb_core #(
        .ADDR_WIDTH(ADDR_WIDTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_op    (s_op),
        .in_value (s_value),
        .res      (pair)
    );

    // result buffering toward the m_ side
    scmb_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (pair),
        .space_ok  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (head)
    );

    assign m_kind    = head.kind;
    assign m_address = head.address;
    assign m_data    = head.data;
    assign m_size    = head.size;
    assign m_last    = head.last;

endmodule

@@ verif/bridge_result_checker.sv @@
// Checker for the serial command memory bridge: predicts each item's results and compares them.
module bridge_result_checker #(
    parameter int ADDR_WIDTH = scmb_pkg::ADDR_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_value,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_kind,
    input  logic [31:0] m_address,
    input  logic [31:0] m_data,
    input  logic [1:0]  m_size,
    input  logic        m_last,
    output int          fail_count,
    output int          outstanding
);
    import scmb_pkg::*;

    localparam logic [63:0] ADDR_MASK_WIDE = (64'd1 << ADDR_WIDTH) - 64'd1;
    localparam logic [31:0] ADDR_MASK      = ADDR_MASK_WIDE[31:0];

    // predicted bridge state
    phase_t      bridge_phase;
    cmd_t        active_cmd;
    logic [2:0]  hdr_count;
    logic [31:0] remaining;
    logic [31:0] cur_addr;
    logic [2:0]  item_width;
    logic [31:0] assembly;
    logic        halted;

    result_t step_results[$];
    result_t pending_results[$];
    int      errors = 0;

    task automatic add_result(input kind_t k, input logic [31:0] a, input logic [31:0] d,
                              input size_t_t sz);
        result_t r;
        r.kind    = k;
        r.address = a;
        r.data    = d;
        r.size    = sz;
        r.last    = 1'b0;
        step_results.push_back(r);
    endtask

    task automatic return_to_idle();
        bridge_phase = PH_IDLE;
        active_cmd   = CMD_NONE;
        hdr_count    = '0;
    endtask

    task automatic reset_bridge_state();
        return_to_idle();
        remaining  = '0;
        cur_addr   = '0;
        item_width = '0;
        assembly   = '0;
        halted     = 1'b0;
    endtask

    // Works out the results of one accepted item and queues them in order.
    task automatic predict_bridge_step(input logic op, input logic [7:0] v);
        result_t     r;
        size_t_t     wsize;
        logic [31:0] wdata;
        step_results.delete();
        if (halted || bridge_phase == PH_HALT)
            return;

        if (op == OP_MEMDATA) begin
            if (bridge_phase == PH_READ) begin
                add_result(KIND_TX, '0, {24'd0, v}, SIZE_BYTE);
                remaining = remaining - 32'd1;
                if (remaining != 0) begin
                    add_result(KIND_RD, cur_addr, '0, SIZE_BYTE);
                    cur_addr = (cur_addr + 32'd1) & ADDR_MASK;
                end else begin
                    return_to_idle();
                end
            end
        end else begin
            case (bridge_phase)
                PH_IDLE: begin
                    hdr_count = '0;
                    assembly  = '0;
                    if (v == CMD_BYTE_PING) begin
                        add_result(KIND_TX, '0, {24'd0, ANS_PING}, SIZE_BYTE);
                    end else if (v == CMD_BYTE_LOAD) begin
                        active_cmd = CMD_LOAD; bridge_phase = PH_HDR8;
                    end else if (v == CMD_BYTE_EXEC) begin
                        active_cmd = CMD_EXEC; bridge_phase = PH_HDR4;
                    end else if (v == CMD_BYTE_JUMP) begin
                        active_cmd = CMD_JUMP; bridge_phase = PH_HDR4;
                    end else if (v == CMD_BYTE_READ) begin
                        active_cmd = CMD_READ; bridge_phase = PH_HDR8;
                    end else if (v == CMD_BYTE_WRITE) begin
                        active_cmd = CMD_WRITE; bridge_phase = PH_WIDTH;
                    end
                end
                PH_WIDTH: begin
                    if (v == {5'd0, WIDTH_BYTE} || v == {5'd0, WIDTH_HALF} ||
                        v == {5'd0, WIDTH_WORD}) begin
                        item_width   = v[2:0];
                        hdr_count    = '0;
                        bridge_phase = PH_HDR8;
                    end else begin
                        return_to_idle();
                    end
                end
                PH_HDR4: begin
                    assembly = {assembly[23:0], v};
                    if (hdr_count >= 3'd3) begin
                        cur_addr = assembly & ADDR_MASK;
                        add_result(KIND_TX, '0, {24'd0, ANS_EXEC}, SIZE_BYTE);
                        if (active_cmd == CMD_JUMP) begin
                            add_result(KIND_JUMP, cur_addr, '0, SIZE_BYTE);
                            halted       = 1'b1;
                            bridge_phase = PH_HALT;
                            active_cmd   = CMD_NONE;
                            hdr_count    = '0;
                        end else begin
                            add_result(KIND_CALL, cur_addr, '0, SIZE_BYTE);
                            return_to_idle();
                        end
                    end else begin
                        hdr_count = hdr_count + 3'd1;
                    end
                end
                PH_HDR8: begin
                    assembly = {assembly[23:0], v};
                    if (hdr_count == 3'd3)
                        remaining = assembly;
                    if (hdr_count < 3'd7) begin
                        hdr_count = hdr_count + 3'd1;
                    end else begin
                        cur_addr  = assembly & ADDR_MASK;
                        hdr_count = '0;
                        assembly  = '0;
                        case (active_cmd)
                            CMD_LOAD: begin
                                if (remaining == 0) begin
                                    add_result(KIND_TX, '0, {24'd0, ANS_LOAD}, SIZE_BYTE);
                                    return_to_idle();
                                end else begin
                                    bridge_phase = PH_LOAD;
                                end
                            end
                            CMD_READ: begin
                                add_result(KIND_TX, '0, {24'd0, ANS_READ}, SIZE_BYTE);
                                if (remaining == 0) begin
                                    return_to_idle();
                                end else begin
                                    add_result(KIND_RD, cur_addr, '0, SIZE_BYTE);
                                    cur_addr     = (cur_addr + 32'd1) & ADDR_MASK;
                                    bridge_phase = PH_READ;
                                end
                            end
                            CMD_WRITE: begin
                                if (remaining == 0) begin
                                    add_result(KIND_TX, '0, {24'd0, ANS_WRITE}, SIZE_BYTE);
                                    return_to_idle();
                                end else begin
                                    bridge_phase = PH_WDATA;
                                end
                            end
                            default: return_to_idle();
                        endcase
                    end
                end
                PH_LOAD: begin
                    add_result(KIND_WR, cur_addr, {24'd0, v}, SIZE_BYTE);
                    cur_addr  = (cur_addr + 32'd1) & ADDR_MASK;
                    remaining = remaining - 32'd1;
                    if (remaining == 0) begin
                        add_result(KIND_TX, '0, {24'd0, ANS_LOAD}, SIZE_BYTE);
                        return_to_idle();
                    end
                end
                PH_WDATA: begin
                    assembly  = {assembly[23:0], v};
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count >= item_width) begin
                        case (item_width)
                            WIDTH_WORD: begin wsize = SIZE_WORD; wdata = assembly; end
                            WIDTH_HALF: begin
                                wsize = SIZE_HALF; wdata = {16'd0, assembly[15:0]};
                            end
                            default: begin wsize = SIZE_BYTE; wdata = {24'd0, assembly[7:0]}; end
                        endcase
                        add_result(KIND_WR, cur_addr, wdata, wsize);
                        cur_addr  = (cur_addr + {29'd0, item_width}) & ADDR_MASK;
                        hdr_count = '0;
                        assembly  = '0;
                        remaining = remaining - 32'd1;
                        if (remaining == 0) begin
                            add_result(KIND_TX, '0, {24'd0, ANS_WRITE}, SIZE_BYTE);
                            return_to_idle();
                        end
                    end
                end
                default: ;
            endcase
        end

        foreach (step_results[i]) begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            pending_results.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
        end
    endtask

    always @(posedge aclk) begin : watch
        result_t want;
        if (!aresetn) begin
            reset_bridge_state();
            pending_results.delete();
            fail_count  <= errors;
            outstanding <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got kind %0d addr %0h data %0h",
                             $time, m_kind, m_address, m_data);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(m_kind));
                    check_field("address", want.address, m_address);
                    check_field("data", want.data, m_data);
                    check_field("size", 32'(want.size), 32'(m_size));
                    check_field("last", 32'(want.last), 32'(m_last));
                end
            end
            // results of an item show from the next cycle, so predicting after the compare is safe
            if (s_valid && s_ready)
                predict_bridge_step(s_op, s_value);
            fail_count  <= errors;
            outstanding <= pending_results.size();
        end
    end

endmodule

@@ verif/serial_command_memory_bridge_top_tb.sv @@
// Testbench top for the serial command memory bridge: stimulus, pacing, watchdog and verdict.
module serial_command_memory_bridge_top_tb;
    import scmb_pkg::*;

    localparam int ITEM_TARGET = 800;   // random part stops once the list is this long
    localparam int CALM_ITEMS  = 120;   // tail of the run with no idling on either side
    localparam int QUIET_LIMIT = 2000;  // cycles without any handshake before giving up
    localparam int DRAIN_WAIT  = 10;    // queue depth plus margin

    typedef struct packed {
        logic       op;
        logic [7:0] value;
    } bridge_item_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_op    = 1'b0;
    logic [7:0]  s_value = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_kind;
    logic [31:0] m_address;
    logic [31:0] m_data;
    logic [1:0]  m_size;
    logic        m_last;

    int fail_count;
    int outstanding;

    bridge_item_t stim_items[$];
    bit           calm         = 1'b0;
    bit           stall_mode   = 1'b0;
    int           stall_left   = 0;
    int           cycle_count  = 0;
    int           quiet_cycles = 0;

    serial_command_memory_bridge_top dut (.*);

    bridge_result_checker checker_i (.*);

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Stimulus list builders. Whole command sequences are laid out up front;
    // the driver below just paces them onto the s_ channel.
    // ---------------------------------------------------------------------
    task automatic send_byte(input logic op, input logic [7:0] v);
        stim_items.push_back({op, v});
    endtask

    // length and address fields go out big-endian
    task automatic send_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--)
            send_byte(OP_SERIAL, w[8*i +: 8]);
    endtask

    // addresses lean on the top of the map so wraparound gets hit often
    function automatic logic [31:0] pick_address();
        case ($urandom_range(0, 7))
            0, 1:    return {28'hFFF_FFFF, 4'($urandom_range(0, 15))};
            2:       return 32'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic seq_load(input logic [31:0] len, input logic [31:0] addr);
        send_byte(OP_SERIAL, CMD_BYTE_LOAD);
        send_word(len);
        send_word(addr);
        for (int i = 0; i < len; i++)
            send_byte(OP_SERIAL, 8'($urandom_range(0, 255)));
    endtask

    task automatic seq_call(input bit is_jump, input logic [31:0] addr);
        send_byte(OP_SERIAL, is_jump ? CMD_BYTE_JUMP : CMD_BYTE_EXEC);
        send_word(addr);
    endtask

    // Returned memory bytes, with stray serial bytes mixed in; the bridge
    // must drop those while a read is running.
    task automatic seq_read(input logic [31:0] len, input logic [31:0] addr, input int stray_pct);
        send_byte(OP_SERIAL, CMD_BYTE_READ);
        send_word(len);
        send_word(addr);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < stray_pct)
                send_byte(OP_SERIAL, 8'($urandom_range(0, 255)));
            send_byte(OP_MEMDATA, 8'($urandom_range(0, 255)));
        end
    endtask

    // A bad width aborts right after the width byte, so nothing else follows it.
    task automatic seq_write(input logic [7:0] width, input logic [31:0] count,
                             input logic [31:0] addr);
        send_byte(OP_SERIAL, CMD_BYTE_WRITE);
        send_byte(OP_SERIAL, width);
        if (width == {5'd0, WIDTH_BYTE} || width == {5'd0, WIDTH_HALF} ||
            width == {5'd0, WIDTH_WORD}) begin
            send_word(count);
            send_word(addr);
            for (int i = 0; i < count * width; i++)
                send_byte(OP_SERIAL, 8'($urandom_range(0, 255)));
        end
    endtask

    // ---------------------------------------------------------------------
    // Stimulus and verdict
    // ---------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] junk;
        bit         gap_mode;
        int         pick;

        // directed part: corners of every command
        send_byte(OP_SERIAL, CMD_BYTE_PING);
        send_byte(OP_SERIAL, 8'h00);              // unknown commands are dropped
        send_byte(OP_SERIAL, 8'hFF);
        send_byte(OP_MEMDATA, 8'hA5);             // memory byte with no read running
        seq_load(32'd0, 32'hFFFF_FFFF);           // zero length answers at once
        seq_load(32'd2, 32'hFFFF_FFFF);           // address wraps to zero
        seq_call(1'b0, 32'hFFFF_FFFF);
        seq_call(1'b0, 32'h0000_0000);
        seq_read(32'd0, 32'h1234_5678, 0);
        seq_read(32'd3, 32'hFFFF_FFFE, 100);      // wraps, stray serial bytes in between
        seq_write(8'd0, 32'd0, 32'd0);            // bad widths abort silently
        seq_write(8'd3, 32'd0, 32'd0);
        seq_write(8'hFF, 32'd0, 32'd0);
        seq_write({5'd0, WIDTH_BYTE}, 32'd0, 32'h8000_0000);
        seq_write({5'd0, WIDTH_BYTE}, 32'd2, 32'h0000_0000);
        seq_write({5'd0, WIDTH_HALF}, 32'd2, 32'hFFFF_FFFF);
        seq_write({5'd0, WIDTH_WORD}, 32'd2, 32'hFFFF_FFFE);

        // random part: mostly well-formed commands, some noise
        while (stim_items.size() < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_byte(OP_SERIAL, CMD_BYTE_PING);
            end else if (pick < 24) begin
                seq_load(($urandom_range(0, 15) == 0) ? $urandom_range(7, 40)
                                                      : $urandom_range(0, 6), pick_address());
            end else if (pick < 36) begin
                seq_call(1'b0, pick_address());
            end else if (pick < 56) begin
                seq_read($urandom_range(0, 6), pick_address(), 25);
            end else if (pick < 82) begin
                case ($urandom_range(0, 2))
                    0:       junk = {5'd0, WIDTH_BYTE};
                    1:       junk = {5'd0, WIDTH_HALF};
                    default: junk = {5'd0, WIDTH_WORD};
                endcase
                seq_write(junk, $urandom_range(0, 5), pick_address());
            end else if (pick < 90) begin
                // answer codes and anything above the command range are not commands
                case ($urandom_range(0, 5))
                    0:       junk = 8'h00;
                    1:       junk = ANS_PING;
                    2:       junk = ANS_LOAD;
                    3:       junk = ANS_EXEC;
                    4:       junk = ANS_READ;
                    default: junk = 8'($urandom_range(11, 255));
                endcase
                send_byte(OP_SERIAL, junk);
            end else if (pick < 95) begin
                send_byte(OP_MEMDATA, 8'($urandom_range(0, 255)));
            end else begin
                junk = $urandom_range(0, 1) ? 8'd3 : 8'($urandom_range(5, 255));
                seq_write(junk, 32'd0, 32'd0);
            end
        end

        // jump halts the bridge for good, so it goes last; the trailing
        // items must then be ignored
        seq_call(1'b1, pick_address());
        for (int i = 0; i < 4; i++)
            send_byte(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (int idx = 0; idx < stim_items.size(); idx++) begin
            if (idx % 50 == 0)
                gap_mode = 1'($urandom_range(0, 1));
            calm = (idx >= stim_items.size() - CALM_ITEMS);
            if (!calm && gap_mode && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_op    <= stim_items[idx].op;
            s_value <= stim_items[idx].value;
            @(posedge aclk);
            while (!s_ready)
                @(posedge aclk);
        end
        s_valid <= 1'b0;

        // the checker's count is registered, so it lags behind the queue
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Result side back-pressure: bursts of stalled cycles of random length, switched
    // on and off at random in windows counted on cycle_count, none in the calm tail.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            stall_mode <= 1'($urandom_range(0, 1));
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (!calm && stall_mode && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 6);
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: a run where neither channel moves for too long is a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
